@@ sv/sbe_pkg.sv @@
// shared types and constants for the spi save-memory slave
`default_nettype none
package sbe_pkg;

  localparam int unsigned MEM_DEPTH_DEF = 65536;
  localparam int unsigned DATA_W        = 8;
  localparam int unsigned ADDR_W        = 24;
  localparam int unsigned MEMB_W        = 19;
  localparam int unsigned CFG_IDX_W     = 2;

  localparam logic [DATA_W-1:0] CMD_WRITE_LO = 8'h02;
  localparam logic [DATA_W-1:0] CMD_READ_LO  = 8'h03;
  localparam logic [DATA_W-1:0] CMD_WR_DIS   = 8'h04;
  localparam logic [DATA_W-1:0] CMD_STATUS   = 8'h05;
  localparam logic [DATA_W-1:0] CMD_WR_EN    = 8'h06;
  localparam logic [DATA_W-1:0] CMD_WRITE_HI = 8'h0A;
  localparam logic [DATA_W-1:0] CMD_READ_HI  = 8'h0B;
  localparam logic [ADDR_W-1:0] HI_START     = 24'h000100;

  localparam logic [1:0]        ADDR_BYTES_RST = 2'd2;
  localparam logic [MEMB_W-1:0] MEM_BYTES_RST  = 19'd65536;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ADDR_BYTES = 2'd0,
    CFG_MEM_BYTES  = 2'd1,
    CFG_STORAGE    = 2'd2,
    CFG_SMALL_MODE = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic [1:0]        address_bytes;
    logic [MEMB_W-1:0] memory_bytes;
    logic              storage_present;
    logic              small_eeprom_mode;
  } cfg_t;

  typedef struct packed {
    logic              we;
    logic              re;
    logic [ADDR_W-1:0] addr;
    logic [DATA_W-1:0] wdata;
  } mem_req_t;

  typedef struct packed {
    logic              sel_mem;
    logic [DATA_W-1:0] data;
  } res_t;

endpackage
`default_nettype wire

@@ sv/sbe_if.sv @@
// valid/ready channel interfaces for the input and result words
`default_nettype none
interface sbe_in_if import sbe_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              opcode;
  logic [DATA_W-1:0] mosi_byte;

  modport source (output valid, output opcode, output mosi_byte, input ready);
  modport sink   (input valid, input opcode, input mosi_byte, output ready);
endinterface

interface sbe_out_if import sbe_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] miso_byte;

  modport source (output valid, output miso_byte, input ready);
  modport sink   (input valid, input miso_byte, output ready);
endinterface
`default_nettype wire

@@ sv/spi_backup_eeprom_slave_top.sv @@
// spi save-memory slave: one exchanged byte (or deselect) in, one reply byte out
//
// in_if carries one word per spi byte: opcode 0 is an exchanged mosi byte,
// opcode 1 a chip deselect. out_if returns one miso byte for every input word,
// in order; a deselect returns zero.
// cfg_we/cfg_index/cfg_wdata write the address width, memory size, storage
// enable and small-part mode; write only while no word is in flight.
// a word passes the middle stage and the output register on its way to out_if; one word
// per cycle is sustained while out_if.ready stays high, set by the single memory port which serves either
// the read or the write of each data byte in the accept cycle.
// a result waits in the output register while out_if.ready is low; the word
// behind it waits in the middle stage, and in_if.ready drops only when both
// are full.
// reset clears command state and write enable and loads the config defaults;
// memory contents stay undefined until written and no clearing pass runs.
`default_nettype none
module spi_backup_eeprom_slave_top import sbe_pkg::*; #(
  parameter int unsigned MEM_DEPTH = MEM_DEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  sbe_in_if.sink               in_if,
  sbe_out_if.source            out_if,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [MEMB_W-1:0]    cfg_wdata
);

  cfg_t              cfg_r;
  mem_req_t          mem_req;
  res_t              res;
  logic [DATA_W-1:0] rdata;
  logic              fire, adv;
  logic              s1_valid_r, s1_sel_r;
  logic [DATA_W-1:0] s1_byte_r;
  logic              out_valid_r;
  logic [DATA_W-1:0] out_byte_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.address_bytes     <= ADDR_BYTES_RST;
      cfg_r.memory_bytes      <= MEM_BYTES_RST;
      cfg_r.storage_present   <= 1'b1;
      cfg_r.small_eeprom_mode <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_ADDR_BYTES: cfg_r.address_bytes     <= cfg_wdata[1:0];
        CFG_MEM_BYTES:  cfg_r.memory_bytes      <= cfg_wdata;
        CFG_STORAGE:    cfg_r.storage_present   <= cfg_wdata[0];
        default:        cfg_r.small_eeprom_mode <= cfg_wdata[0];
      endcase
    end
  end

  assign adv         = !out_valid_r || out_if.ready;
  assign in_if.ready = !s1_valid_r || adv;
  assign fire        = in_if.valid && in_if.ready;

  sbe_ctrl #(.MEM_DEPTH(MEM_DEPTH)) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (fire),
    .opcode    (in_if.opcode),
    .mosi_byte (in_if.mosi_byte),
    .cfg       (cfg_r),
    .mem_req   (mem_req),
    .res       (res)
  );

  sbe_mem #(.MEM_DEPTH(MEM_DEPTH)) u_mem (
    .clk     (clk),
    .req     (mem_req),
    .rdata_r (rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_if.ready) s1_valid_r <= in_if.valid;
      if (adv) out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      s1_sel_r  <= res.sel_mem;
      s1_byte_r <= res.data;
    end
    if (adv && s1_valid_r) out_byte_r <= s1_sel_r ? rdata : s1_byte_r;
  end

  assign out_if.valid     = out_valid_r;
  assign out_if.miso_byte = out_byte_r;

endmodule
`default_nettype wire

@@ sv/sbe_ctrl.sv @@
// command decoder and control state, issues memory requests per word
`default_nettype none
module sbe_ctrl import sbe_pkg::*; #(
  parameter int unsigned MEM_DEPTH = MEM_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              fire,
  input  logic              opcode,
  input  logic [DATA_W-1:0] mosi_byte,
  input  cfg_t              cfg,
  output mem_req_t          mem_req,
  output res_t              res
);

  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_READ   = 2'd1,
    PH_WRITE  = 2'd2,
    PH_STATUS = 2'd3
  } phase_t;

  phase_t            phase_r, phase_nxt;
  logic [ADDR_W-1:0] addr_r, addr_nxt;
  logic [1:0]        left_r, left_nxt;
  logic              wen_r, wen_nxt;
  logic              in_range;
  logic              we, re;

  assign in_range = (addr_r < {5'd0, cfg.memory_bytes}) &&
                    ({1'b0, addr_r} < (ADDR_W+1)'(MEM_DEPTH));

  always_comb begin
    phase_nxt   = phase_r;
    addr_nxt    = addr_r;
    left_nxt    = left_r;
    wen_nxt     = wen_r;
    we          = 1'b0;
    re          = 1'b0;
    res.sel_mem = 1'b0;
    res.data    = mosi_byte;
    if (opcode) begin
      if (phase_r == PH_WRITE) wen_nxt = 1'b0;
      phase_nxt = PH_IDLE;
      res.data  = '0;
    end else begin
      unique case (phase_r)
        PH_READ, PH_WRITE: begin
          if (left_r != 2'd0) begin
            left_nxt = left_r - 2'd1;
            unique case (left_nxt)
              2'd0:    addr_nxt = {addr_r[23:8], addr_r[7:0] | mosi_byte};
              2'd1:    addr_nxt = {addr_r[23:16], addr_r[15:8] | mosi_byte, addr_r[7:0]};
              default: addr_nxt = {addr_r[23:16] | mosi_byte, addr_r[15:0]};
            endcase
          end else if (in_range) begin
            if (phase_r == PH_READ) begin
              re          = 1'b1;
              res.sel_mem = 1'b1;
            end else begin
              we = 1'b1;
            end
            addr_nxt = addr_r + 24'd1;
          end
        end
        PH_STATUS: res.data = {6'd0, wen_r, 1'b0};
        default: begin
          unique case (mosi_byte)
            CMD_WRITE_LO, CMD_WRITE_HI: begin
              if (wen_r) begin
                phase_nxt = PH_WRITE;
                left_nxt  = cfg.address_bytes;
                addr_nxt  = (mosi_byte == CMD_WRITE_HI && cfg.small_eeprom_mode) ?
                            HI_START : '0;
              end else begin
                res.data = '0;
              end
            end
            CMD_READ_LO, CMD_READ_HI: begin
              phase_nxt = PH_READ;
              left_nxt  = cfg.address_bytes;
              addr_nxt  = (mosi_byte == CMD_READ_HI && cfg.small_eeprom_mode) ?
                          HI_START : '0;
            end
            CMD_WR_DIS: wen_nxt = 1'b0;
            CMD_STATUS: phase_nxt = PH_STATUS;
            CMD_WR_EN:  if (cfg.storage_present) wen_nxt = 1'b1;
            default: ;
          endcase
        end
      endcase
    end
  end

  assign mem_req.we    = fire && we;
  assign mem_req.re    = fire && re;
  assign mem_req.addr  = addr_r;
  assign mem_req.wdata = mosi_byte;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      addr_r  <= '0;
      left_r  <= '0;
      wen_r   <= 1'b0;
    end else if (fire) begin
      phase_r <= phase_nxt;
      addr_r  <= addr_nxt;
      left_r  <= left_nxt;
      wen_r   <= wen_nxt;
    end
  end

endmodule
`default_nettype wire

@@ sv/sbe_mem.sv @@
// byte storage, one synchronous port with registered read data
`default_nettype none
module sbe_mem import sbe_pkg::*; #(
  parameter int unsigned MEM_DEPTH = MEM_DEPTH_DEF
) (
  input  logic              clk,
  input  mem_req_t          req,
  output logic [DATA_W-1:0] rdata_r
);

  localparam int unsigned AW = $clog2(MEM_DEPTH);

  logic [DATA_W-1:0] mem_r [MEM_DEPTH];

  always_ff @(posedge clk) begin
    if (req.we) mem_r[req.addr[AW-1:0]] <= req.wdata;
    if (req.re) rdata_r <= mem_r[req.addr[AW-1:0]];
  end

endmodule
`default_nettype wire

@@ sv/sbe_checker.sv @@
// port-level checks for the spi save-memory slave, bound to the top level
`default_nettype none
module sbe_checker import sbe_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              in_opcode,
  input logic              out_valid,
  input logic              out_ready,
  input logic [DATA_W-1:0] out_miso
);

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_miso))
    else $error("stalled output word changed");

  a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled while output free");

  a_deselect_zero: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_opcode ##1 out_ready |=> out_valid && out_miso == '0)
    else $error("deselect did not return zero");

endmodule

bind spi_backup_eeprom_slave_top sbe_checker u_sbe_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_if.valid),
  .in_ready  (in_if.ready),
  .in_opcode (in_if.opcode),
  .out_valid (out_if.valid),
  .out_ready (out_if.ready),
  .out_miso  (out_if.miso_byte)
);
`default_nettype wire

@@ tb/sv/spi_backup_eeprom_slave_top_tb.sv @@
// testbench for the spi save-memory slave: directed command table, then random command streams
module spi_backup_eeprom_slave_top_tb;
  import sbe_pkg::*;

  localparam int unsigned DEPTH    = MEM_DEPTH_DEF;
  localparam int unsigned WATCHDOG = 2000000;
  localparam int          DIR_ROWS = 26;

  typedef enum logic [1:0] {PH_IDLE, PH_READ, PH_WRITE, PH_STATUS} cmd_phase_t;

  typedef struct packed {
    logic              deselect;
    logic [DATA_W-1:0] mosi;
    logic              fixed;
    logic [DATA_W-1:0] miso;
  } dir_row_t;

  localparam dir_row_t DIRECTED [DIR_ROWS] = '{
    '{1'b1, 8'h00,        1'b1, 8'h00},
    '{1'b0, 8'h00,        1'b1, 8'h00},
    '{1'b0, 8'hFF,        1'b1, 8'hFF},
    '{1'b0, CMD_WRITE_LO, 1'b1, 8'h00},
    '{1'b0, CMD_WRITE_HI, 1'b1, 8'h00},
    '{1'b0, CMD_STATUS,   1'b1, CMD_STATUS},
    '{1'b0, 8'h37,        1'b1, 8'h00},
    '{1'b1, 8'h00,        1'b1, 8'h00},
    '{1'b0, CMD_WR_EN,    1'b1, CMD_WR_EN},
    '{1'b0, CMD_WR_DIS,   1'b1, CMD_WR_DIS},
    '{1'b0, CMD_WR_EN,    1'b1, CMD_WR_EN},
    '{1'b0, CMD_STATUS,   1'b1, CMD_STATUS},
    '{1'b0, 8'hAA,        1'b1, 8'h02},
    '{1'b1, 8'h00,        1'b1, 8'h00},
    '{1'b0, CMD_WRITE_LO, 1'b1, CMD_WRITE_LO},
    '{1'b0, 8'hFF,        1'b1, 8'hFF},
    '{1'b0, 8'hFF,        1'b1, 8'hFF},
    '{1'b0, 8'h5A,        1'b1, 8'h5A},
    '{1'b0, 8'hC3,        1'b1, 8'hC3},
    '{1'b1, 8'h00,        1'b1, 8'h00},
    '{1'b0, CMD_READ_HI,  1'b1, CMD_READ_HI},
    '{1'b0, 8'hFF,        1'b1, 8'hFF},
    '{1'b0, 8'hFF,        1'b1, 8'hFF},
    '{1'b0, 8'h00,        1'b0, 8'h00},
    '{1'b0, 8'h11,        1'b1, 8'h11},
    '{1'b1, 8'hFF,        1'b1, 8'h00}
  };

  localparam logic [DATA_W-1:0] CMD_MENU [7] = '{
    CMD_WRITE_LO, CMD_READ_LO, CMD_WR_DIS, CMD_STATUS, CMD_WR_EN, CMD_WRITE_HI, CMD_READ_HI
  };

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [MEMB_W-1:0]    cfg_wdata;

  sbe_in_if  in_if ();
  sbe_out_if out_if ();

  spi_backup_eeprom_slave_top #(.MEM_DEPTH(DEPTH)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (in_if),
    .out_if    (out_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  cfg_t              cfg_shadow;
  cmd_phase_t        cmd_phase;
  logic [ADDR_W-1:0] cur_addr;
  logic [1:0]        addr_left;
  logic              wr_en;
  logic [DATA_W-1:0] mem_copy [DEPTH];
  bit                filled [DEPTH];
  logic [ADDR_W-1:0] filled_addrs [$];
  logic [DATA_W-1:0] miso_q [$];
  bit                gaps_on;
  bit                stalls_on;
  int unsigned       words_sent;
  int unsigned       replies_seen;
  int unsigned       mismatches;
  int unsigned       mem_reads;
  int unsigned       mem_writes;
  int unsigned       refused_writes;
  int unsigned       settings_used;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic bit addr_in_use(input logic [ADDR_W-1:0] a);
    return (a < ADDR_W'(cfg_shadow.memory_bytes)) && (a < ADDR_W'(DEPTH));
  endfunction

  function automatic void open_access(input cmd_phase_t ph, input bit high_half);
    cur_addr  = (high_half && cfg_shadow.small_eeprom_mode) ? HI_START : '0;
    addr_left = cfg_shadow.address_bytes;
    cmd_phase = ph;
  endfunction

  function automatic logic [DATA_W-1:0] exchange_byte(input logic deselect,
                                                      input logic [DATA_W-1:0] mosi);
    logic [DATA_W-1:0] miso;
    miso = mosi;
    if (deselect) begin
      if (cmd_phase == PH_WRITE) wr_en = 1'b0;
      cmd_phase = PH_IDLE;
      return '0;
    end
    case (cmd_phase)
      PH_READ, PH_WRITE: begin
        if (addr_left != 2'd0) begin
          addr_left = addr_left - 2'd1;
          cur_addr  = cur_addr | (ADDR_W'(mosi) << (8 * addr_left));
        end else if (addr_in_use(cur_addr)) begin
          if (cmd_phase == PH_READ) begin
            miso = mem_copy[cur_addr];
            mem_reads++;
          end else begin
            mem_copy[cur_addr] = mosi;
            if (!filled[cur_addr]) filled_addrs.push_back(cur_addr);
            filled[cur_addr] = 1'b1;
            mem_writes++;
          end
          cur_addr = cur_addr + 1'b1;
        end
      end
      PH_STATUS: miso = {6'd0, wr_en, 1'b0};
      default: begin
        case (mosi)
          CMD_WRITE_LO, CMD_WRITE_HI: begin
            if (wr_en) begin
              open_access(PH_WRITE, mosi == CMD_WRITE_HI);
            end else begin
              miso = '0;
              refused_writes++;
            end
          end
          CMD_READ_LO, CMD_READ_HI: open_access(PH_READ, mosi == CMD_READ_HI);
          CMD_WR_DIS: wr_en = 1'b0;
          CMD_STATUS: cmd_phase = PH_STATUS;
          CMD_WR_EN: begin
            if (cfg_shadow.storage_present) wr_en = 1'b1;
          end
          default: ;
        endcase
      end
    endcase
    return miso;
  endfunction

  // next data byte would read a location never written since reset
  function automatic bit reads_blank();
    return cmd_phase == PH_READ && addr_left == 2'd0 && addr_in_use(cur_addr)
           && !filled[cur_addr];
  endfunction

  function automatic logic [ADDR_W-1:0] pick_target(input bit for_read);
    int unsigned span;
    int unsigned roll;
    span = (cfg_shadow.memory_bytes < DEPTH) ? cfg_shadow.memory_bytes : DEPTH;
    roll = $urandom_range(0, 99);
    if (filled_addrs.size() != 0 && roll < (for_read ? 70 : 30))
      return filled_addrs[$urandom_range(0, filled_addrs.size() - 1)];
    if (roll < 85 && span != 0) return ADDR_W'($urandom_range(0, span - 1));
    if (roll < 95) return ADDR_W'(span + $urandom_range(0, 4) - 2);
    return ADDR_W'($urandom);
  endfunction

  function automatic void note_miss(input string what, input logic [DATA_W-1:0] want,
                                    input logic [DATA_W-1:0] got);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch on %s at reply %0d: expected %h, got %h", what, replies_seen, want, got);
  endfunction

  task automatic send_word(input logic deselect, input logic [DATA_W-1:0] mosi,
                           input bit fixed = 1'b0, input logic [DATA_W-1:0] miso_fixed = '0);
    logic [DATA_W-1:0] want;
    while (gaps_on && $urandom_range(0, 99) < 10) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid     <= 1'b1;
    in_if.opcode    <= deselect;
    in_if.mosi_byte <= mosi;
    do @(posedge clk); while (!in_if.ready);
    want = exchange_byte(deselect, mosi);
    miso_q.push_back(fixed ? miso_fixed : want);
    words_sent++;
  endtask

  task automatic send_safe(input logic deselect, input logic [DATA_W-1:0] mosi);
    send_word(deselect || reads_blank(), mosi);
  endtask

  task automatic apply_settings(input logic [1:0] addr_bytes, input logic [MEMB_W-1:0] mem_bytes,
                                input logic storage, input logic small_mode);
    if (cmd_phase != PH_IDLE) send_word(1'b1, 8'h00);
    in_if.valid <= 1'b0;
    while (miso_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_ADDR_BYTES;
    cfg_wdata <= MEMB_W'(addr_bytes);
    @(posedge clk);
    cfg_index <= CFG_MEM_BYTES;
    cfg_wdata <= mem_bytes;
    @(posedge clk);
    cfg_index <= CFG_STORAGE;
    cfg_wdata <= MEMB_W'(storage);
    @(posedge clk);
    cfg_index <= CFG_SMALL_MODE;
    cfg_wdata <= MEMB_W'(small_mode);
    @(posedge clk);
    cfg_we <= 1'b0;
    cfg_shadow.address_bytes     = addr_bytes;
    cfg_shadow.memory_bytes      = mem_bytes;
    cfg_shadow.storage_present   = storage;
    cfg_shadow.small_eeprom_mode = small_mode;
    settings_used++;
  endtask

  task automatic run_traffic(input int unsigned n_words);
    int unsigned       stop_at;
    int unsigned       roll;
    int unsigned       len;
    int unsigned       k;
    logic [ADDR_W-1:0] target;
    stop_at = words_sent + n_words;
    while (words_sent < stop_at) begin
      roll = $urandom_range(0, 99);
      len  = $urandom_range(1, 8);
      if (roll < 80) begin
        if (roll < 45) begin
          if (!wr_en && $urandom_range(0, 9) != 0) send_safe(1'b0, CMD_WR_EN);
          send_safe(1'b0, $urandom_range(0, 1) ? CMD_WRITE_HI : CMD_WRITE_LO);
        end else begin
          send_safe(1'b0, $urandom_range(0, 1) ? CMD_READ_HI : CMD_READ_LO);
        end
        target = pick_target(roll >= 45);
        for (k = cfg_shadow.address_bytes; k > 0; k--) send_safe(1'b0, target[8*(k-1) +: 8]);
        for (k = 0; k < len && !reads_blank(); k++) send_safe(1'b0, 8'($urandom));
        if ($urandom_range(0, 9) != 0) send_safe(1'b1, 8'($urandom));
      end else if (roll < 88) begin
        send_safe(1'b0, CMD_STATUS);
        repeat (len % 3 + 1) send_safe(1'b0, 8'($urandom));
        send_safe(1'b1, 8'($urandom));
      end else begin
        repeat (len % 4 + 1)
          send_safe($urandom_range(0, 4) == 0,
                    $urandom_range(0, 1) ? CMD_MENU[$urandom_range(0, 6)] : 8'($urandom));
      end
    end
  endtask

  initial begin
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      out_if.ready <= !stalls_on || ($urandom_range(0, 99) >= 10);
    end
  end

  always @(posedge clk) begin : reply_check
    logic [DATA_W-1:0] want;
    if (rst_n && out_if.valid && out_if.ready) begin
      replies_seen++;
      if (miso_q.size() == 0) begin
        note_miss("unexpected reply", 'x, out_if.miso_byte);
      end else begin
        want = miso_q.pop_front();
        if (out_if.miso_byte !== want) note_miss("miso_byte", want, out_if.miso_byte);
      end
    end
  end

  initial begin
    #(WATCHDOG);
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    in_if.valid     <= 1'b0;
    in_if.opcode    <= 1'b0;
    in_if.mosi_byte <= '0;
    cfg_we          <= 1'b0;
    cfg_index       <= CFG_ADDR_BYTES;
    cfg_wdata       <= '0;
    rst_n           <= 1'b0;
    gaps_on         <= 1'b1;
    stalls_on       <= 1'b1;
    cfg_shadow.address_bytes     = ADDR_BYTES_RST;
    cfg_shadow.memory_bytes      = MEM_BYTES_RST;
    cfg_shadow.storage_present   = 1'b1;
    cfg_shadow.small_eeprom_mode = 1'b0;
    cmd_phase = PH_IDLE;
    cur_addr  = '0;
    addr_left = '0;
    wr_en     = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < DIR_ROWS; i++)
      send_word(DIRECTED[i].deselect, DIRECTED[i].mosi, DIRECTED[i].fixed, DIRECTED[i].miso);

    apply_settings(2'd1, 19'd512, 1'b1, 1'b1);
    run_traffic(160);
    apply_settings(2'd3, 19'd262144, 1'b1, 1'b0);
    run_traffic(160);
    // back-to-back stretch, no gaps and no stalls
    gaps_on   <= 1'b0;
    stalls_on <= 1'b0;
    apply_settings(2'd0, 19'd300, 1'b1, 1'b1);
    run_traffic(160);
    gaps_on   <= 1'b1;
    stalls_on <= 1'b1;
    apply_settings(2'd2, 19'd0, 1'b1, 1'b0);
    run_traffic(120);
    apply_settings(2'd2, 19'd65535, 1'b0, 1'b1);
    run_traffic(140);
    apply_settings(ADDR_BYTES_RST, MEM_BYTES_RST, 1'b1, 1'b0);
    run_traffic(160);
    repeat (3) begin
      apply_settings(2'($urandom_range(0, 3)),
                     19'($urandom_range(0, 1) ? $urandom_range(0, 262144)
                                              : $urandom_range(0, 2048)),
                     1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      run_traffic(160);
    end

    in_if.valid <= 1'b0;
    while (miso_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    $display("exchanged %0d words under %0d register settings, %0d replies checked",
             words_sent, settings_used + 1, replies_seen);
    $display("memory reads %0d, memory writes %0d, refused writes %0d, mismatches %0d",
             mem_reads, mem_writes, refused_writes, mismatches);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
